### hdl/snv_pkg.sv
// shared types, constants and edge tables for the surface-net cube vertex block
// no dependencies; every other source file but snv_div and snv_delay imports this package
package snv_pkg;

    localparam int CUBE_W       = 8;
    localparam int GRID_DIM     = 256;
    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 16;
    localparam int N_EDGES      = 12;
    localparam int N_CORNERS    = 8;
    localparam int N_AXES       = 3;
    localparam int CNT_W        = 4;
    localparam int BASE_W       = 12;
    localparam int T_W          = FRAC_BITS + 1;
    localparam int SUM_W        = 28;
    localparam int COORD_W      = 32;
    localparam int RES_W        = 31;
    localparam int LO_W         = RES_W + FRAC_BITS;
    localparam int HI_W         = RES_W + SUM_W - FRAC_BITS;
    localparam int Q1_W         = HI_W;
    localparam int NQ_W         = Q1_W + 1;
    localparam int ACC_W        = NQ_W + 2;
    localparam int CFG_IDX_W    = 2;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CNT_W-1:0]   MIN_CROSS = CNT_W'(3);
    localparam logic [RES_W-1:0]   RES_RESET = RES_W'(65536);
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // corner index bit 0 is x, bit 1 is y, bit 2 is z
    localparam logic [2:0] EDGE_C1 [N_EDGES] =
        '{3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6};
    localparam logic [2:0] EDGE_C2 [N_EDGES] =
        '{3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd6, 3'd7, 3'd5, 3'd6, 3'd7, 3'd7};
    localparam logic [2:0] EDGE_DIR [N_EDGES] =
        '{3'd1, 3'd2, 3'd4, 3'd2, 3'd4, 3'd1, 3'd4, 3'd4, 3'd1, 3'd2, 3'd2, 3'd1};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X   = 2'd0,
        REG_ORIGIN_Y   = 2'd1,
        REG_ORIGIN_Z   = 2'd2,
        REG_RESOLUTION = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] num;
        logic [SAMPLE_BITS-1:0] den;
    } edge_div_t;

    typedef struct packed {
        logic [N_EDGES-1:0]             crossed;
        logic [CNT_W-1:0]               count;
        logic [N_AXES-1:0][BASE_W-1:0]  base;
    } cube_info_t;

    typedef struct packed {
        edge_div_t [N_EDGES-1:0] edges;
        cube_info_t              info;
    } cube_entry_t;

    typedef struct packed {
        logic       live;
        cube_info_t info;
    } side_t;

endpackage

### hdl/surface_net_cube_vertex.sv
// Surface-nets vertex for one grid cube: takes one cube per cycle while the queue
// is not full and returns one result per cube, in order. A short queue parts the
// sign classifier from the arithmetic pipeline, which is set by a 17-stage
// divider for the edge fractions, three stages of sum and scaling, and an
// 11-stage divider for the mean. Output stall holds the whole arithmetic
// pipeline; input stall rises only once the queue is full.
// depends on snv_pkg, snv_front, snv_queue, snv_back
module surface_net_cube_vertex #(
    parameter int QUEUE_DEPTH = snv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [snv_pkg::CUBE_W-1:0]             cube_x,
    input  logic [snv_pkg::CUBE_W-1:0]             cube_y,
    input  logic [snv_pkg::CUBE_W-1:0]             cube_z,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_000,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_100,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_010,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_110,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_001,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_101,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_011,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_111,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [snv_pkg::COORD_W-1:0]     vertex_x,
    output logic signed [snv_pkg::COORD_W-1:0]     vertex_y,
    output logic signed [snv_pkg::COORD_W-1:0]     vertex_z,
    output logic                                   vertex_valid,
    output logic [snv_pkg::CNT_W-1:0]              crossed_edges,
    input  logic                                   cfg_write,
    input  logic [snv_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [snv_pkg::COORD_W-1:0]            cfg_data
);
    import snv_pkg::*;

    logic [CUBE_W-1:0]           cube [N_AXES];
    logic signed [SAMPLE_BITS-1:0] corner [N_CORNERS];
    cube_entry_t                 front_entry, head_entry;
    logic                        q_full, q_empty, q_push, q_pop, adv;
    logic signed [COORD_W-1:0]   origin_reg [N_AXES];
    logic [RES_W-1:0]            res_reg;

    assign cube   = '{cube_x, cube_y, cube_z};
    assign corner = '{corner_000, corner_100, corner_010, corner_110,
                      corner_001, corner_101, corner_011, corner_111};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            res_reg       <= RES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:   origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y:   origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z:   origin_reg[2] <= cfg_data;
                REG_RESOLUTION: res_reg       <= cfg_data[RES_W-1:0];
                default:        ;
            endcase
        end
    end

    snv_front u_front (
        .cube   (cube),
        .corner (corner),
        .entry  (front_entry)
    );

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_pop    = adv && !q_empty;

    snv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (front_entry),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (head_entry)
    );

    // an empty queue feeds a bubble into the pipeline
    snv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .live_in       (!q_empty),
        .entry         (head_entry),
        .origin        (origin_reg),
        .resolution    (res_reg),
        .adv           (adv),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .vertex_z      (vertex_z),
        .vertex_valid  (vertex_valid),
        .crossed_edges (crossed_edges)
    );

endmodule

### hdl/snv_front.sv
// front end: classifies corner signs, counts crossings and prepares edge divisions
// depends on snv_pkg
module snv_front (
    input  logic [snv_pkg::CUBE_W-1:0]             cube [snv_pkg::N_AXES],
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner [snv_pkg::N_CORNERS],
    output snv_pkg::cube_entry_t                   entry
);
    import snv_pkg::*;

    logic [N_CORNERS-1:0]        neg;
    logic [CUBE_W-1:0]           cube_m [N_AXES];
    logic [CNT_W-1:0]            fixed_cnt [N_AXES];
    logic [CNT_W-1:0]            count;
    logic [N_EDGES-1:0]          crossed;
    logic signed [SAMPLE_BITS:0] s1_ext [N_EDGES];
    logic signed [SAMPLE_BITS:0] diff [N_EDGES];

    always_comb
    begin
        for (int i = 0; i < N_CORNERS; i++)
        begin
            neg[i] = corner[i][SAMPLE_BITS-1];
        end
        for (int a = 0; a < N_AXES; a++)
        begin
            cube_m[a]    = CUBE_W'(cube[a] % GRID_DIM);
            fixed_cnt[a] = '0;
        end
        count = '0;
        for (int e = 0; e < N_EDGES; e++)
        begin
            crossed[e] = neg[EDGE_C1[e]] ^ neg[EDGE_C2[e]];
            s1_ext[e]  = {corner[EDGE_C1[e]][SAMPLE_BITS-1], corner[EDGE_C1[e]]};
            diff[e]    = s1_ext[e] - {corner[EDGE_C2[e]][SAMPLE_BITS-1], corner[EDGE_C2[e]]};
            entry.edges[e].num = s1_ext[e][SAMPLE_BITS] ? SAMPLE_BITS'(-s1_ext[e])
                                                         : SAMPLE_BITS'(s1_ext[e]);
            entry.edges[e].den = diff[e][SAMPLE_BITS] ? SAMPLE_BITS'(-diff[e])
                                                       : SAMPLE_BITS'(diff[e]);
            count = count + CNT_W'(crossed[e]);
            for (int a = 0; a < N_AXES; a++)
            begin
                // off-axis edges sit on the far face when their first corner does
                if (crossed[e] && !EDGE_DIR[e][a] && EDGE_C1[e][a])
                begin
                    fixed_cnt[a] = fixed_cnt[a] + 1'b1;
                end
            end
        end
        entry.info.crossed = crossed;
        entry.info.count   = count;
        for (int a = 0; a < N_AXES; a++)
        begin
            entry.info.base[a] = BASE_W'(cube_m[a]) * BASE_W'(count) + BASE_W'(fixed_cnt[a]);
        end
    end

endmodule

### hdl/snv_queue.sv
// short queue between the front end and the arithmetic back end
// depends on snv_pkg
module snv_queue #(
    parameter int DEPTH = snv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  snv_pkg::cube_entry_t din,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output snv_pkg::cube_entry_t dout
);
    import snv_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    cube_entry_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_QW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### hdl/snv_div.sv
// pipelined restoring divider, STEPS quotient bits per stage
// depends on nothing but its parameters
module snv_div #(
    parameter int DW    = 24,
    parameter int QW    = 17,
    parameter int STEPS = 1
) (
    input  logic          clk,
    input  logic          adv,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] work_in,
    input  logic [DW-1:0] den_in,
    output logic [QW-1:0] quo_out
);
    localparam int STAGES = QW / STEPS;

    logic [DW-1:0] rem_reg  [STAGES];
    logic [QW-1:0] work_reg [STAGES];
    logic [DW-1:0] den_reg  [STAGES];

    // work shifts dividend bits out at the top and quotient bits in at the bottom
    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [DW-1:0] r_src, d_src, r_nx;
        logic [QW-1:0] w_src, w_nx;
        logic [DW:0]   r_ext;

        if (k == 0)
        begin : g_first
            assign r_src = rem_in;
            assign w_src = work_in;
            assign d_src = den_in;
        end
        else
        begin : g_next
            assign r_src = rem_reg[k-1];
            assign w_src = work_reg[k-1];
            assign d_src = den_reg[k-1];
        end

        always_comb
        begin
            r_nx  = r_src;
            w_nx  = w_src;
            r_ext = '0;
            for (int j = 0; j < STEPS; j++)
            begin
                r_ext = {r_nx, w_nx[QW-1]};
                w_nx  = {w_nx[QW-2:0], 1'b0};
                if (r_ext >= {1'b0, d_src})
                begin
                    r_nx    = DW'(r_ext - {1'b0, d_src});
                    w_nx[0] = 1'b1;
                end
                else
                begin
                    r_nx = r_ext[DW-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= r_nx;
                work_reg[k] <= w_nx;
                den_reg[k]  <= d_src;
            end
        end
    end

    assign quo_out = work_reg[STAGES-1];

endmodule

### hdl/snv_delay.sv
// control delay line that keeps item tags aligned with the divider pipelines
// depends on nothing but its parameters
module snv_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                tap_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            tap_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

### hdl/snv_back.sv
// back end: edge fractions, per-axis sums, scaling, mean and saturation, output register
// depends on snv_pkg, snv_div and snv_delay
module snv_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               live_in,
    input  snv_pkg::cube_entry_t               entry,
    input  logic signed [snv_pkg::COORD_W-1:0] origin [snv_pkg::N_AXES],
    input  logic [snv_pkg::RES_W-1:0]          resolution,
    output logic                               adv,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [snv_pkg::COORD_W-1:0] vertex_x,
    output logic signed [snv_pkg::COORD_W-1:0] vertex_y,
    output logic signed [snv_pkg::COORD_W-1:0] vertex_z,
    output logic                               vertex_valid,
    output logic [snv_pkg::CNT_W-1:0]          crossed_edges
);
    import snv_pkg::*;

    localparam int T_STEPS  = 1;
    localparam int N_STEPS  = 4;
    localparam int T_STAGES = T_W / T_STEPS;
    localparam int N_STAGES = NQ_W / N_STEPS;

    logic [T_W-1:0]      t_val [N_EDGES];
    side_t               side_in, side_t_out, side_fin;
    side_t               side_sum_reg, side_mul_reg, side_add_reg;
    logic [SUM_W-1:0]    sum_next [N_AXES];
    logic [SUM_W-1:0]    sum_reg [N_AXES];
    logic [LO_W-1:0]     lo_reg [N_AXES];
    logic [HI_W-1:0]     hi_reg [N_AXES];
    logic [Q1_W-1:0]     q1_reg [N_AXES];
    logic [NQ_W-1:0]     off [N_AXES];
    logic [ACC_W-1:0]    total [N_AXES];
    logic [COORD_W-1:0]  sat [N_AXES];
    logic                out_valid_reg;
    logic [COORD_W-1:0]  vx_reg, vy_reg, vz_reg;
    logic                vvalid_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                enough;

    // the whole back end moves as one when the output register can take a result
    assign adv     = !out_valid_reg || !out_stall;
    assign side_in = '{live: live_in, info: entry.info};

    // crossing fraction t = |s1| * 2^16 / |s1 - s2|, quotient below 2^17
    for (genvar e = 0; e < N_EDGES; e++)
    begin : g_edge
        snv_div #(
            .DW    (SAMPLE_BITS),
            .QW    (T_W),
            .STEPS (T_STEPS)
        ) u_tdiv (
            .clk     (clk),
            .adv     (adv),
            .rem_in  (SAMPLE_BITS'(entry.edges[e].num >> 1)),
            .work_in ({entry.edges[e].num[0], {FRAC_BITS{1'b0}}}),
            .den_in  (entry.edges[e].den),
            .quo_out (t_val[e])
        );
    end

    snv_delay #(
        .W     ($bits(side_t)),
        .DEPTH (T_STAGES)
    ) u_tside (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .d     (side_in),
        .q     (side_t_out)
    );

    always_comb
    begin
        for (int a = 0; a < N_AXES; a++)
        begin
            sum_next[a] = {side_t_out.info.base[a], {FRAC_BITS{1'b0}}};
            for (int e = 0; e < N_EDGES; e++)
            begin
                if (side_t_out.info.crossed[e] && EDGE_DIR[e][a])
                begin
                    sum_next[a] = sum_next[a] + SUM_W'(t_val[e]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < N_AXES; a++)
            begin
                sum_reg[a] <= sum_next[a];
                // resolution * sum split in two partial products
                lo_reg[a]  <= LO_W'(resolution) * LO_W'(sum_reg[a][FRAC_BITS-1:0]);
                hi_reg[a]  <= HI_W'(resolution) * HI_W'(sum_reg[a][SUM_W-1:FRAC_BITS]);
                q1_reg[a]  <= hi_reg[a] + Q1_W'(lo_reg[a][LO_W-1:FRAC_BITS]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_sum_reg <= '0;
            side_mul_reg <= '0;
            side_add_reg <= '0;
        end
        else if (adv)
        begin
            side_sum_reg <= side_t_out;
            side_mul_reg <= side_sum_reg;
            side_add_reg <= side_mul_reg;
        end
    end

    // mean: (product >> 16) / crossing count
    for (genvar a = 0; a < N_AXES; a++)
    begin : g_axis
        snv_div #(
            .DW    (CNT_W),
            .QW    (NQ_W),
            .STEPS (N_STEPS)
        ) u_ndiv (
            .clk     (clk),
            .adv     (adv),
            .rem_in  ('0),
            .work_in ({1'b0, q1_reg[a]}),
            .den_in  (side_add_reg.info.count),
            .quo_out (off[a])
        );
    end

    snv_delay #(
        .W     ($bits(side_t)),
        .DEPTH (N_STAGES)
    ) u_nside (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .d     (side_add_reg),
        .q     (side_fin)
    );

    always_comb
    begin
        for (int a = 0; a < N_AXES; a++)
        begin
            total[a] = ACC_W'(origin[a]) + {2'b00, off[a]};
            if (total[a][ACC_W-1:COORD_W-1] == '0 || total[a][ACC_W-1:COORD_W-1] == '1)
            begin
                sat[a] = total[a][COORD_W-1:0];
            end
            else if (total[a][ACC_W-1])
            begin
                sat[a] = COORD_MIN;
            end
            else
            begin
                sat[a] = COORD_MAX;
            end
        end
        enough = (side_fin.info.count >= MIN_CROSS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= side_fin.live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg     <= enough ? sat[0] : '0;
            vy_reg     <= enough ? sat[1] : '0;
            vz_reg     <= enough ? sat[2] : '0;
            vvalid_reg <= enough;
            cnt_reg    <= side_fin.info.count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign vertex_x      = vx_reg;
    assign vertex_y      = vy_reg;
    assign vertex_z      = vz_reg;
    assign vertex_valid  = vvalid_reg;
    assign crossed_edges = cnt_reg;

endmodule

### hdl/snv_check.sv
// port-level checks on the result channel of the surface-net cube vertex block
// depends on snv_pkg; bound to surface_net_cube_vertex below
module snv_check (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [snv_pkg::COORD_W-1:0] vertex_x,
    input logic signed [snv_pkg::COORD_W-1:0] vertex_y,
    input logic signed [snv_pkg::COORD_W-1:0] vertex_z,
    input logic                               vertex_valid,
    input logic [snv_pkg::CNT_W-1:0]          crossed_edges
);
    import snv_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex_x) && $stable(vertex_y)
                                   && $stable(vertex_z) && $stable(crossed_edges))
        else $error("stalled result changed");

    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vertex_valid == (crossed_edges >= MIN_CROSS))
        else $error("vertex flag disagrees with crossing count");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !vertex_valid |-> vertex_x == '0 && vertex_y == '0 && vertex_z == '0)
        else $error("invalid vertex not cleared");

    // the crossing count can never exceed N_EDGES, the number of cube edges
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> crossed_edges <= CNT_W'(N_EDGES))
        else $error("impossible crossing count");

endmodule

bind surface_net_cube_vertex snv_check u_check (.*);

### tb/snv_checker.sv
// checker for the surface-net cube vertex block: watches both channels and the register port
// predicts each vertex from the accepted cube and compares; depends on snv_pkg
module snv_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic [snv_pkg::CUBE_W-1:0]             cube_x,
    input  logic [snv_pkg::CUBE_W-1:0]             cube_y,
    input  logic [snv_pkg::CUBE_W-1:0]             cube_z,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_000,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_100,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_010,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_110,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_001,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_101,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_011,
    input  logic signed [snv_pkg::SAMPLE_BITS-1:0] corner_111,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic signed [snv_pkg::COORD_W-1:0]     vertex_x,
    input  logic signed [snv_pkg::COORD_W-1:0]     vertex_y,
    input  logic signed [snv_pkg::COORD_W-1:0]     vertex_z,
    input  logic                                   vertex_valid,
    input  logic [snv_pkg::CNT_W-1:0]              crossed_edges,
    input  logic                                   cfg_write,
    input  logic [snv_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [snv_pkg::COORD_W-1:0]            cfg_data,
    output int                                     pending,
    output int                                     errors
);
    import snv_pkg::*;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               ok;
        logic [3:0]         cnt;
    } vertex_t;

    vertex_t vertex_q[$];
    logic signed [31:0] org_x = 0, org_y = 0, org_z = 0;
    logic [30:0]        res = RES_RESET;

    // corner indices per edge, bit 0 x, bit 1 y, bit 2 z
    const int end_a[12] = '{0, 0, 0, 1, 1, 2, 2, 3, 4, 4, 5, 6};
    const int end_b[12] = '{1, 2, 4, 3, 5, 3, 6, 7, 5, 6, 7, 7};

    assign pending = vertex_q.size();

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic vertex_t predict_vertex(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz,
                                               longint s[8]);
        vertex_t r;
        longint unsigned sum[3];
        longint unsigned cube[3];
        longint t16;
        longint s1, s2;
        longint unsigned off;
        int n;
        int d;
        cube[0] = cx; cube[1] = cy; cube[2] = cz;
        sum = '{0, 0, 0};
        n = 0;
        for (int e = 0; e < 12; e++) begin
            s1 = s[end_a[e]];
            s2 = s[end_b[e]];
            if ((s1 < 0) != (s2 < 0)) begin
                t16 = (s1 * 65536) / (s1 - s2);
                d = end_a[e] ^ end_b[e];
                for (int a = 0; a < 3; a++)
                    if ((d >> a) & 1)
                        sum[a] += (cube[a] << 16) + t16;
                    else
                        sum[a] += (cube[a] << 16) + (((end_a[e] >> a) & 1) << 16);
                n++;
            end
        end
        r.cnt = 4'(n);
        r.ok = (n >= 3);
        r.vx = 0; r.vy = 0; r.vz = 0;
        if (n >= 3) begin
            off = (longint'(res) * sum[0]) / (longint'(n) << 16);
            r.vx = clamp32(longint'(org_x) + longint'(off));
            off = (longint'(res) * sum[1]) / (longint'(n) << 16);
            r.vy = clamp32(longint'(org_y) + longint'(off));
            off = (longint'(res) * sum[2]) / (longint'(n) << 16);
            r.vz = clamp32(longint'(org_z) + longint'(off));
        end
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk) begin
        longint smp[8];
        vertex_t w;
        if (rst_n) begin
            if (cfg_write)
                case (cfg_reg_t'(cfg_index))
                    REG_ORIGIN_X:   org_x = cfg_data;
                    REG_ORIGIN_Y:   org_y = cfg_data;
                    REG_ORIGIN_Z:   org_z = cfg_data;
                    REG_RESOLUTION: res = cfg_data[30:0];
                    default:        ;
                endcase
            if (in_valid && !in_stall) begin
                smp = '{corner_000, corner_100, corner_010, corner_110,
                        corner_001, corner_101, corner_011, corner_111};
                vertex_q.push_back(predict_vertex(cube_x, cube_y, cube_z, smp));
            end
            if (out_valid && !out_stall) begin
                if (vertex_q.size() == 0) begin
                    $display("unexpected vertex transfer at %0t", $time);
                    errors++;
                end else begin
                    w = vertex_q.pop_front();
                    if (vertex_x !== w.vx) report("vertex_x", vertex_x, w.vx);
                    if (vertex_y !== w.vy) report("vertex_y", vertex_y, w.vy);
                    if (vertex_z !== w.vz) report("vertex_z", vertex_z, w.vz);
                    if (vertex_valid !== w.ok) report("vertex_valid", vertex_valid, w.ok);
                    if (crossed_edges !== w.cnt) report("crossed_edges", crossed_edges, w.cnt);
                end
            end
        end
    end
endmodule

### tb/tb.sv
// top of the surface-net cube vertex testbench: clock, reset, stimulus and verdict
// depends on snv_pkg, surface_net_cube_vertex and snv_checker
module tb;
    import snv_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, in_stall, out_valid, out_stall = 0;
    logic [7:0] cube_x = 0, cube_y = 0, cube_z = 0;
    logic signed [23:0] c000 = 0, c100 = 0, c010 = 0, c110 = 0;
    logic signed [23:0] c001 = 0, c101 = 0, c011 = 0, c111 = 0;
    logic signed [31:0] vertex_x, vertex_y, vertex_z;
    logic vertex_valid;
    logic [3:0] crossed_edges;
    logic cfg_write = 0;
    logic [1:0] cfg_index = 0;
    logic [31:0] cfg_data = 0;
    int pending, errors;
    bit idle_on = 1;

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    surface_net_cube_vertex dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cube_x(cube_x), .cube_y(cube_y), .cube_z(cube_z),
        .corner_000(c000), .corner_100(c100), .corner_010(c010), .corner_110(c110),
        .corner_001(c001), .corner_101(c101), .corner_011(c011), .corner_111(c111),
        .out_valid(out_valid), .out_stall(out_stall),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .vertex_valid(vertex_valid), .crossed_edges(crossed_edges),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    snv_checker chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cube_x(cube_x), .cube_y(cube_y), .cube_z(cube_z),
        .corner_000(c000), .corner_100(c100), .corner_010(c010), .corner_110(c110),
        .corner_001(c001), .corner_101(c101), .corner_011(c011), .corner_111(c111),
        .out_valid(out_valid), .out_stall(out_stall),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .vertex_valid(vertex_valid), .crossed_edges(crossed_edges),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .errors(errors)
    );

    // receiver stalls at random while idle_on is set
    always @(negedge clk)
        out_stall <= idle_on && ($urandom_range(99) < 34);

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'sd0;
            3: return 24'($urandom_range(255) - 128);
            default: return 24'($urandom);
        endcase
    endfunction

    // called at a falling edge; valid stays up after the transfer so items can follow
    task automatic send_cube(logic [7:0] x, y, z, logic signed [23:0] s[8]);
        while (idle_on && $urandom_range(99) < 34)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        cube_x <= x; cube_y <= y; cube_z <= z;
        c000 <= s[0]; c100 <= s[1]; c010 <= s[2]; c110 <= s[3];
        c001 <= s[4]; c101 <= s[5]; c011 <= s[6]; c111 <= s[7];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 0;
    endtask

    task automatic random_cube(bit near_surface);
        logic signed [23:0] s[8];
        for (int i = 0; i < 8; i++)
        begin
            s[i] = near_surface ? rand_sample() : 24'($urandom);
            // mostly straddle zero so edges cross
            if (near_surface && $urandom_range(1)) s[i] = -s[i];
        end
        send_cube(8'($urandom), 8'($urandom), 8'($urandom), s);
    endtask

    initial
    begin
        logic signed [23:0] s[8];
        logic [31:0] orgs[4][3];
        logic [30:0] ress[4];
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: all outside, all inside, zero samples, extremes, single corner
        s = '{0, 0, 0, 0, 0, 0, 0, 0};
        send_cube(0, 0, 0, s);
        s = '{-1, -1, -1, -1, -1, -1, -1, -1};
        send_cube(255, 255, 255, s);
        s = '{24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000,
              24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff};
        send_cube(255, 255, 255, s);
        s = '{-1, 0, 0, 0, 0, 0, 0, 0};
        send_cube(128, 1, 254, s);
        s = '{-65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536};
        send_cube(7, 8, 9, s);
        s = '{24'sh800000, 1, 1, 1, 1, 1, 1, 1};
        send_cube(0, 255, 0, s);
        s = '{-5, -5, 0, 0, 3, 3, 0, 0};
        send_cube(85, 170, 15, s);
        s = '{1, -1, 0, 0, 0, 0, 0, 0};
        send_cube(3, 3, 3, s);
        drain();

        orgs = '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
                 '{32'h80000000, 32'h80000000, 32'h80000000},
                 '{32'h00012345, 32'hfff00000, 32'h0},
                 '{32'h0, 32'h0, 32'h0}};
        ress = '{31'h7fffffff, 31'd1, 31'd0, 31'd65536};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_ORIGIN_X, orgs[ph][0]);
            write_reg(REG_ORIGIN_Y, orgs[ph][1]);
            write_reg(REG_ORIGIN_Z, orgs[ph][2]);
            write_reg(REG_RESOLUTION, {1'b0, ress[ph]});
            if (ph == 1) idle_on = 0;
            for (int i = 0; i < 30; i++) random_cube(1);
            idle_on = 1;
            drain();
        end

        write_reg(REG_ORIGIN_X, $urandom);
        write_reg(REG_ORIGIN_Y, $urandom);
        write_reg(REG_ORIGIN_Z, $urandom);
        write_reg(REG_RESOLUTION, $urandom_range(200000));
        for (int i = 0; i < 380; i++)
        begin
            if (i == 150) idle_on = 0;
            if (i == 230) idle_on = 1;
            random_cube($urandom_range(99) < 80);
        end
        drain();

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #200000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

### files.f
hdl/snv_pkg.sv
hdl/snv_front.sv
hdl/snv_queue.sv
hdl/snv_div.sv
hdl/snv_delay.sv
hdl/snv_back.sv
hdl/surface_net_cube_vertex.sv
hdl/snv_check.sv
tb/snv_checker.sv
tb/tb.sv
